>>> rtl/dsma_pkg.sv
// ----------------------------------------------------------------------------
// dsma_pkg: shared types and constants
// Widths, register indexes, commands and sequencer states of the ADC
// deadband, scale and moving-average block.
// ----------------------------------------------------------------------------
`default_nettype none

package dsma_pkg;

    localparam int ADC_BITS     = 10;
    localparam int MAPPED_BITS  = 12;
    localparam int WINDOW_DEPTH = 16;

    localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = MAPPED_BITS + $clog2(WINDOW_DEPTH + 1);
    localparam int AVG_W  = 16;
    localparam int FRAC_W = 4;

    // Span of the map: signed difference of two mapped values
    localparam int SPAN_W = MAPPED_BITS + 1;
    // Product of the source offset (kept signed) and the span
    localparam int PROD_W = ADC_BITS + 1 + SPAN_W;

    // Shared divider: dividend covers |product| and the scaled window sum
    localparam int MAPDIV_W = ADC_BITS + MAPPED_BITS;
    localparam int AVGDIV_W = SUM_W + FRAC_W;
    localparam int DIV_W    = (MAPDIV_W > AVGDIV_W) ? MAPDIV_W : AVGDIV_W;
    localparam int DEN_W    = (ADC_BITS > FILL_W) ? ADC_BITS : FILL_W;
    localparam int DCNT_W   = $clog2(DIV_W);

    // Stream payload widths
    localparam int S_TDATA_W = ((ADC_BITS + 7) / 8) * 8;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = ((AVG_W + FILL_W + 7) / 8) * 8;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ADC_FLOOR    = 3'd0,
        CFG_ADC_CEILING  = 3'd1,
        CFG_TARGET_MIN   = 3'd2,
        CFG_TARGET_MAX   = 3'd3,
        CFG_AVG_LOW      = 3'd4,
        CFG_AVG_HIGH     = 3'd5,
        CFG_NOISE_EPS    = 3'd6,
        CFG_DB_ENABLE    = 3'd7
    } cfg_reg_t;

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_CLEAR  = 1'b1
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_MAP_START,
        ST_MAP_WAIT,
        ST_UPDATE,
        ST_AVG_START,
        ST_AVG_WAIT,
        ST_CLAMP,
        ST_CLEAR,
        ST_OUT
    } seq_state_t;

endpackage

`default_nettype wire

>>> rtl/dsma_div.sv
// ----------------------------------------------------------------------------
// dsma_div: shared restoring divider
// Unsigned division, one quotient bit per cycle; done pulses for one cycle
// once the quotient is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module dsma_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [dsma_pkg::DIV_W-1:0] dividend,
    input  wire logic [dsma_pkg::DEN_W-1:0] divisor,
    output logic                            done,
    output logic [dsma_pkg::DIV_W-1:0]      quotient
);
    import dsma_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]  quot_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;

    logic [DEN_W:0]    trial;
    logic              fits;
    logic [DEN_W:0]    trial_diff;

    // Shift the next dividend bit into the partial remainder and try a subtract
    assign trial      = {rem_reg, quot_reg[DIV_W-1]};
    assign fits       = (trial >= {1'b0, den_reg});
    assign trial_diff = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == DCNT_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            den_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[DIV_W-2:0], fits};
            rem_reg  <= fits ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

>>> rtl/adc_deadband_scale_moving_average_top.sv
// Sequence: a sample item passes prep, multiply, the map divide (skipped when
//   the ceiling is not above the floor), window update, the average divide,
//   clamp and output; a clear item goes from the clear step to output.
// One item at a time: the next is taken once the last result is loaded for
//   output, after up to two 22-step divisions on the one shared divider and any output stall.
// Reset: asynchronous, active low; control registers reset at once, window starts empty.
// ----------------------------------------------------------------------------
// adc_deadband_scale_moving_average_top: ADC conditioning filter
// Deadband, clamp, linear map and boxcar moving average of converter
// samples, sequenced around one shared divider.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_deadband_scale_moving_average_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Input stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [dsma_pkg::S_TDATA_W-1:0]      s_tdata,  // [9:0] adc_sample
    input  wire logic [dsma_pkg::S_TUSER_W-1:0]      s_tuser,  // [0] command
    // Result stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [dsma_pkg::M_TDATA_W-1:0]           m_tdata,  // [15:0] average_value,
                                                               // [20:16] samples_held
    // Configuration write channel
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [dsma_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [dsma_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import dsma_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ADC_BITS-1:0]    adc_floor_reg;
    logic [ADC_BITS-1:0]    adc_ceiling_reg;
    logic [MAPPED_BITS-1:0] target_min_reg;
    logic [MAPPED_BITS-1:0] target_max_reg;
    logic [AVG_W-1:0]       avg_low_reg;
    logic [AVG_W-1:0]       avg_high_reg;
    logic [ADC_BITS-1:0]    noise_eps_reg;
    logic                   db_enable_reg;

    // Each write goes straight into its register, so never stall the channel
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adc_floor_reg   <= '0;
            adc_ceiling_reg <= '1;
            target_min_reg  <= '0;
            target_max_reg  <= '1;
            avg_low_reg     <= '0;
            avg_high_reg    <= '1;
            noise_eps_reg   <= '0;
            db_enable_reg   <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_ADC_FLOOR:   adc_floor_reg   <= cfg_data[ADC_BITS-1:0];
                CFG_ADC_CEILING: adc_ceiling_reg <= cfg_data[ADC_BITS-1:0];
                CFG_TARGET_MIN:  target_min_reg  <= cfg_data[MAPPED_BITS-1:0];
                CFG_TARGET_MAX:  target_max_reg  <= cfg_data[MAPPED_BITS-1:0];
                CFG_AVG_LOW:     avg_low_reg     <= cfg_data[AVG_W-1:0];
                CFG_AVG_HIGH:    avg_high_reg    <= cfg_data[AVG_W-1:0];
                CFG_NOISE_EPS:   noise_eps_reg   <= cfg_data[ADC_BITS-1:0];
                CFG_DB_ENABLE:   db_enable_reg   <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    seq_state_t state_reg;
    seq_state_t state_next;

    logic s_accept;
    logic div_start;
    logic div_done;
    logic out_load;
    logic flat_reg;

    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = (cmd_t'(s_tuser[0]) == CMD_CLEAR) ? ST_CLEAR : ST_PREP;
                end
            end
            ST_PREP:      state_next = ST_MUL;
            ST_MUL:       state_next = ST_MAP_START;
            ST_MAP_START:
            begin
                // A flat source range maps straight to target_min: skip the divide
                div_start  = !flat_reg;
                state_next = flat_reg ? ST_UPDATE : ST_MAP_WAIT;
            end
            ST_MAP_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:    state_next = ST_AVG_START;
            ST_AVG_START:
            begin
                div_start  = 1'b1;
                state_next = ST_AVG_WAIT;
            end
            ST_AVG_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP:     state_next = ST_OUT;
            ST_CLEAR:     state_next = ST_OUT;
            ST_OUT:
            begin
                // Hold here until the output register is free
                if (!m_tvalid || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Deadband and clamp
    // ------------------------------------------------------------------
    logic [ADC_BITS-1:0] sample_reg;
    logic [ADC_BITS-1:0] held_reg;
    logic [ADC_BITS-1:0] reading_reg;

    logic [ADC_BITS-1:0] db_diff;
    logic                db_take;
    logic [ADC_BITS-1:0] held_next;
    logic [ADC_BITS-1:0] reading_raw;
    logic [ADC_BITS-1:0] reading_next;

    always_comb
    begin
        // True absolute difference from the held reading
        db_diff = (sample_reg > held_reg) ? (sample_reg - held_reg)
                                          : (held_reg - sample_reg);
        db_take = (noise_eps_reg == '0) || (db_diff > noise_eps_reg);
        held_next = held_reg;
        if (db_enable_reg && db_take)
        begin
            held_next = sample_reg;
        end
        reading_raw = db_enable_reg ? held_next : sample_reg;
        // Floor is checked first, then the ceiling
        priority if (reading_raw < adc_floor_reg)
        begin
            reading_next = adc_floor_reg;
        end
        else if (reading_raw > adc_ceiling_reg)
        begin
            reading_next = adc_ceiling_reg;
        end
        else
        begin
            reading_next = reading_raw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else if (state_reg == ST_PREP)
        begin
            held_reg <= held_next;
        end
    end

    // ------------------------------------------------------------------
    // Linear map: tmin + (reading - floor) * (tmax - tmin) / (ceiling - floor)
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [ADC_BITS:0]  offset_s;
    logic signed [SPAN_W-1:0]  span_s;
    logic [ADC_BITS-1:0]       offset;
    logic [PROD_W-1:0]         prod_abs;
    logic                      neg_reg;
    logic [MAPPED_BITS-1:0]    mapped_reg;
    logic [MAPPED_BITS-1:0]    quot_low;

    assign offset    = reading_reg - adc_floor_reg;
    assign offset_s  = $signed({1'b0, offset});
    assign span_s    = $signed({1'b0, target_max_reg}) - $signed({1'b0, target_min_reg});
    assign prod_next = PROD_W'(offset_s) * PROD_W'(span_s);
    assign prod_abs  = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);

    // ------------------------------------------------------------------
    // Shared divider: map quotient, then the average
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]  sum_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [DIV_W-1:0]  div_dividend;
    logic [DEN_W-1:0]  div_divisor;
    logic [DIV_W-1:0]  div_quot;

    always_comb
    begin
        if (state_reg == ST_AVG_START)
        begin
            div_dividend = DIV_W'({sum_reg, {FRAC_W{1'b0}}});
            div_divisor  = DEN_W'(fill_reg);
        end
        else
        begin
            div_dividend = prod_abs[DIV_W-1:0];
            div_divisor  = DEN_W'(adc_ceiling_reg - adc_floor_reg);
        end
    end

    dsma_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Truncated quotient, negated for a downward slope; wraps to the map width
    assign quot_low = div_quot[MAPPED_BITS-1:0];

    // ------------------------------------------------------------------
    // Window ring, running sum and fill count
    // ------------------------------------------------------------------
    logic [MAPPED_BITS-1:0] window_mem [WINDOW_DEPTH];
    logic [MAPPED_BITS-1:0] old_reg;
    logic [MAPPED_BITS-1:0] old_entry;
    logic [SLOT_W-1:0]      slot_reg;
    logic                   window_full;

    // Entries fill in order after a clear, so a slot holds data only once full
    assign window_full = (fill_reg == FILL_W'(WINDOW_DEPTH));
    assign old_entry   = window_full ? old_reg : '0;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_PREP)
        begin
            old_reg <= window_mem[slot_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_UPDATE)
        begin
            window_mem[slot_reg] <= mapped_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            slot_reg <= '0;
            fill_reg <= '0;
        end
        else if (state_reg == ST_CLEAR)
        begin
            sum_reg  <= '0;
            slot_reg <= '0;
            fill_reg <= '0;
        end
        else if (state_reg == ST_UPDATE)
        begin
            sum_reg <= sum_reg - SUM_W'(old_entry) + SUM_W'(mapped_reg);
            if (slot_reg == SLOT_W'(WINDOW_DEPTH - 1))
            begin
                slot_reg <= '0;
            end
            else
            begin
                slot_reg <= slot_reg + 1'b1;
            end
            if (!window_full)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers along the sequence
    // ------------------------------------------------------------------
    logic [AVGDIV_W-1:0] avg_reg;
    logic [AVG_W-1:0]    res_avg_reg;
    logic [FILL_W-1:0]   res_fill_reg;

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            sample_reg <= s_tdata[ADC_BITS-1:0];
        end
        if (state_reg == ST_PREP)
        begin
            reading_reg <= reading_next;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= prod_next;
            flat_reg <= (adc_ceiling_reg <= adc_floor_reg);
        end
        if (state_reg == ST_MAP_START)
        begin
            neg_reg <= prod_reg[PROD_W-1];
            if (flat_reg)
            begin
                mapped_reg <= target_min_reg;
            end
        end
        if (state_reg == ST_MAP_WAIT && div_done)
        begin
            mapped_reg <= target_min_reg + (neg_reg ? MAPPED_BITS'(-quot_low) : quot_low);
        end
        if (state_reg == ST_AVG_WAIT && div_done)
        begin
            avg_reg <= div_quot[AVGDIV_W-1:0];
        end
        if (state_reg == ST_CLAMP)
        begin
            // Low limit first, so crossed limits give the low limit when below it
            priority if (avg_reg < AVGDIV_W'(avg_low_reg))
            begin
                res_avg_reg <= avg_low_reg;
            end
            else if (avg_reg > AVGDIV_W'(avg_high_reg))
            begin
                res_avg_reg <= avg_high_reg;
            end
            else
            begin
                res_avg_reg <= avg_reg[AVG_W-1:0];
            end
            res_fill_reg <= fill_reg;
        end
        if (state_reg == ST_CLEAR)
        begin
            // A clear reports zero, not clamped to the limits
            res_avg_reg  <= '0;
            res_fill_reg <= '0;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= M_TDATA_W'({res_fill_reg, res_avg_reg});
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

>>> rtl/dsma_checker.sv
// ----------------------------------------------------------------------------
// dsma_checker: port-level checks
// Watches the stream ports of the ADC filter top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module dsma_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    input  wire logic                             s_tready,
    input  wire logic                             m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic [dsma_pkg::M_TDATA_W-1:0]   m_tdata
);
    import dsma_pkg::*;

    localparam int HELD_LO = AVG_W;
    localparam int HELD_HI = AVG_W + FILL_W - 1;

    // Stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One item at a time: ready drops right after an input is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // Window count never exceeds the window depth
    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[HELD_HI:HELD_LO] <= FILL_W'(WINDOW_DEPTH))
        else $error("samples_held out of range");

    // An empty window reports a zero average
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[HELD_HI:HELD_LO] == '0) |-> m_tdata[AVG_W-1:0] == '0)
        else $error("non-zero average with an empty window");

endmodule

bind adc_deadband_scale_moving_average_top dsma_checker u_dsma_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
